/* rtl/complex_arith_unit_defines.svh */
// Assertion macros shared by the complex arithmetic unit RTL.
`ifndef COMPLEX_ARITH_UNIT_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CAU_ASSERT(lbl, clk, rst_n, prop, msg)
`define CAU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/cau_pkg.sv */
// Shared types and constants of the complex arithmetic unit.
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_DIV = 2'd3;

  localparam int MODE_W  = 2;
  localparam int FLAGS_W = 5;

  typedef struct packed {
    logic is_div;
    logic dz;
    logic neg_re;
    logic neg_im;
    logic ovf_re;
    logic ovf_im;
    logic eq;
    logic lt;
    logic gt;
  } cau_flags_t;

endpackage

/* rtl/cau_front.sv */
// Input register, products, operand sums and divider setup of the complex unit.
module cau_front #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [cau_pkg::MODE_W-1:0]    in_mode,
  input  logic [DATA_WIDTH-1:0]         in_a_re,
  input  logic [DATA_WIDTH-1:0]         in_a_im,
  input  logic [DATA_WIDTH-1:0]         in_b_re,
  input  logic [DATA_WIDTH-1:0]         in_b_im,
  output logic                          o_valid,
  output cau_pkg::cau_flags_t           o_flags,
  output logic [2*DATA_WIDTH-1:0]       o_num_re,
  output logic [2*DATA_WIDTH-1:0]       o_num_im,
  output logic [2*DATA_WIDTH-1:0]       o_den,
  output logic [2*DATA_WIDTH:0]         o_rem_re,
  output logic [2*DATA_WIDTH:0]         o_rem_im
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int MW = 2 * W;
  localparam int RW = 2 * W + 1;
  localparam int QB = W + 1;
  localparam int NW = MW + F;
  localparam int CW = (NW - QB > MW) ? NW - QB : MW;

  // stage 0
  logic                   v0_r;
  logic [MODE_W-1:0]      mode0_r;
  logic signed [W-1:0]    ar_r, ai_r, br_r, bi_r;

  // stage 1
  logic                   v1_r;
  logic [MODE_W-1:0]      mode1_r;
  logic signed [PW-1:0]   p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_cc_r;
  logic signed [W:0]      as_re_r, as_im_r;
  logic                   eq1_r, lt1_r, gt1_r;

  // stage 2
  logic                   v2_r;
  cau_flags_t             fl2_r;
  logic [MW-1:0]          mag_re_r, mag_im_r, den2_r;

  logic signed [SW-1:0]   s_re, s_im, abs_re, abs_im;
  logic [MW-1:0]          mag_re_nxt, mag_im_nxt, den_nxt;
  cau_flags_t             fl2_nxt, fl3_nxt;
  logic                   lt_re, eq_re, lt_im, eq_im;

  logic [NW-1:0]          n_re, n_im;
  logic [CW-1:0]          r0_re, r0_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      v0_r    <= in_valid;
      v1_r    <= v0_r;
      v2_r    <= v1_r;
      o_valid <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode0_r <= in_mode;
      ar_r    <= in_a_re;
      ai_r    <= in_a_im;
      br_r    <= in_b_re;
      bi_r    <= in_b_im;
    end
  end

  always_comb begin
    eq_re = (ar_r == br_r);
    lt_re = (ar_r < br_r);
    eq_im = (ai_r == bi_r);
    lt_im = (ai_r < bi_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1_r <= mode0_r;
      p_rr_r  <= PW'(ar_r) * PW'(br_r);
      p_ii_r  <= PW'(ai_r) * PW'(bi_r);
      p_ri_r  <= PW'(ar_r) * PW'(bi_r);
      p_ir_r  <= PW'(ai_r) * PW'(br_r);
      p_bb_r  <= PW'(br_r) * PW'(br_r);
      p_cc_r  <= PW'(bi_r) * PW'(bi_r);
      as_re_r <= (mode0_r == MODE_SUB) ? ((W+1)'(ar_r) - (W+1)'(br_r))
                                       : ((W+1)'(ar_r) + (W+1)'(br_r));
      as_im_r <= (mode0_r == MODE_SUB) ? ((W+1)'(ai_r) - (W+1)'(bi_r))
                                       : ((W+1)'(ai_r) + (W+1)'(bi_r));
      eq1_r   <= eq_re && eq_im;
      lt1_r   <= lt_re || (eq_re && lt_im);
      gt1_r   <= (!lt_re && !eq_re) || (eq_re && !lt_im && !eq_im);
    end
  end

  always_comb begin
    case (mode1_r)
      MODE_MUL: begin
        s_re = SW'(p_rr_r) - SW'(p_ii_r);
        s_im = SW'(p_ri_r) + SW'(p_ir_r);
      end
      MODE_DIV: begin
        s_re = SW'(p_rr_r) + SW'(p_ii_r);
        s_im = SW'(p_ir_r) - SW'(p_ri_r);
      end
      default: begin
        s_re = SW'(as_re_r);
        s_im = SW'(as_im_r);
      end
    endcase
    abs_re     = s_re[SW-1] ? -s_re : s_re;
    abs_im     = s_im[SW-1] ? -s_im : s_im;
    mag_re_nxt = abs_re[MW-1:0];
    mag_im_nxt = abs_im[MW-1:0];
    if (mode1_r == MODE_MUL) begin
      mag_re_nxt = abs_re[MW-1:0] >> F;
      mag_im_nxt = abs_im[MW-1:0] >> F;
    end
    den_nxt        = MW'(p_bb_r) + MW'(p_cc_r);
    fl2_nxt        = '0;
    fl2_nxt.is_div = (mode1_r == MODE_DIV);
    fl2_nxt.neg_re = s_re[SW-1];
    fl2_nxt.neg_im = s_im[SW-1];
    fl2_nxt.eq     = eq1_r;
    fl2_nxt.lt     = lt1_r;
    fl2_nxt.gt     = gt1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl2_r    <= fl2_nxt;
      mag_re_r <= mag_re_nxt;
      mag_im_r <= mag_im_nxt;
      den2_r   <= den_nxt;
    end
  end

  always_comb begin
    n_re           = {mag_re_r, {F{1'b0}}};
    n_im           = {mag_im_r, {F{1'b0}}};
    r0_re          = CW'(n_re >> QB);
    r0_im          = CW'(n_im >> QB);
    fl3_nxt        = fl2_r;
    fl3_nxt.dz     = fl2_r.is_div && (den2_r == '0);
    fl3_nxt.ovf_re = fl2_r.is_div && (r0_re >= CW'(den2_r));
    fl3_nxt.ovf_im = fl2_r.is_div && (r0_im >= CW'(den2_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_flags  <= fl3_nxt;
      o_num_re <= mag_re_r;
      o_num_im <= mag_im_r;
      o_den    <= den2_r;
      o_rem_re <= RW'(n_re >> QB);
      o_rem_im <= RW'(n_im >> QB);
    end
  end

endmodule

/* rtl/cau_div_cell.sv */
// One quotient-bit cell of the divider chain, both result parts.
module cau_div_cell #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
  parameter int BIT_POS    = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    i_valid,
  input  cau_pkg::cau_flags_t     i_flags,
  input  logic [2*DATA_WIDTH-1:0] i_num_re,
  input  logic [2*DATA_WIDTH-1:0] i_num_im,
  input  logic [2*DATA_WIDTH-1:0] i_den,
  input  logic [2*DATA_WIDTH:0]   i_rem_re,
  input  logic [2*DATA_WIDTH:0]   i_rem_im,
  input  logic [DATA_WIDTH:0]     i_q_re,
  input  logic [DATA_WIDTH:0]     i_q_im,
  output logic                    o_valid,
  output cau_pkg::cau_flags_t     o_flags,
  output logic [2*DATA_WIDTH-1:0] o_num_re,
  output logic [2*DATA_WIDTH-1:0] o_num_im,
  output logic [2*DATA_WIDTH-1:0] o_den,
  output logic [2*DATA_WIDTH:0]   o_rem_re,
  output logic [2*DATA_WIDTH:0]   o_rem_im,
  output logic [DATA_WIDTH:0]     o_q_re,
  output logic [DATA_WIDTH:0]     o_q_im
);
  import cau_pkg::*;

  localparam int RW = 2 * DATA_WIDTH + 1;
  localparam int QB = DATA_WIDTH + 1;

  logic          nbit_re, nbit_im;
  logic [RW-1:0] sh_re, sh_im, den_x;
  logic          ge_re, ge_im;

  generate
    if (BIT_POS >= FRAC_BITS) begin : g_num_bit
      assign nbit_re = i_num_re[BIT_POS-FRAC_BITS];
      assign nbit_im = i_num_im[BIT_POS-FRAC_BITS];
    end else begin : g_zero_bit
      assign nbit_re = 1'b0;
      assign nbit_im = 1'b0;
    end
  endgenerate

  always_comb begin
    den_x = RW'(i_den);
    sh_re = {i_rem_re[RW-2:0], nbit_re};
    sh_im = {i_rem_im[RW-2:0], nbit_im};
    ge_re = (sh_re >= den_x);
    ge_im = (sh_im >= den_x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_flags  <= i_flags;
      o_num_re <= i_num_re;
      o_num_im <= i_num_im;
      o_den    <= i_den;
      o_rem_re <= ge_re ? sh_re - den_x : sh_re;
      o_rem_im <= ge_im ? sh_im - den_x : sh_im;
      o_q_re   <= {i_q_re[QB-2:0], ge_re};
      o_q_im   <= {i_q_im[QB-2:0], ge_im};
    end
  end

endmodule

/* rtl/cau_out.sv */
// Saturation and output register of the complex arithmetic unit.
`include "complex_arith_unit_defines.svh"
module cau_out #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    i_valid,
  input  cau_pkg::cau_flags_t     i_flags,
  input  logic [2*DATA_WIDTH-1:0] i_num_re,
  input  logic [2*DATA_WIDTH-1:0] i_num_im,
  input  logic [DATA_WIDTH:0]     i_q_re,
  input  logic [DATA_WIDTH:0]     i_q_im,
  output logic                    o_valid,
  output logic [DATA_WIDTH-1:0]   o_res_re,
  output logic [DATA_WIDTH-1:0]   o_res_im,
  output logic [cau_pkg::FLAGS_W-1:0] o_flags
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int MW = 2 * W;
  localparam logic [MW-1:0] HALF = MW'(1) << (W - 1);

  logic [MW-1:0] mag_re, mag_im;
  logic [W:0]    sat_re, sat_im;
  logic          clip;

  function automatic logic [W:0] saturate(input logic [MW-1:0] mag, input logic neg,
                                          input logic ovf);
    logic [MW-1:0] lim;
    logic [MW-1:0] m;
    logic          c;
    lim = neg ? HALF : HALF - MW'(1);
    c   = ovf || (mag > lim);
    m   = c ? lim : mag;
    return {c, neg ? -m[W-1:0] : m[W-1:0]};
  endfunction

  always_comb begin
    mag_re = i_flags.is_div ? MW'(i_q_re) : i_num_re;
    mag_im = i_flags.is_div ? MW'(i_q_im) : i_num_im;
    sat_re = saturate(mag_re, i_flags.neg_re, i_flags.ovf_re);
    sat_im = saturate(mag_im, i_flags.neg_im, i_flags.ovf_im);
    if (i_flags.dz) begin
      sat_re = '0;
      sat_im = '0;
    end
    clip = sat_re[W] || sat_im[W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_res_re <= sat_re[W-1:0];
      o_res_im <= sat_im[W-1:0];
      o_flags  <= {i_flags.gt, i_flags.lt, i_flags.eq, i_flags.dz, clip};
    end
  end

  `CAU_ASSERT(a_dz_zero, clk, rst_n, (o_valid && o_flags[1]) |-> (o_res_re == '0 && o_res_im == '0 && !o_flags[0]), "divide by zero result not cleared")
  `CAU_ASSERT(a_cmp_onehot, clk, rst_n, o_valid |-> $onehot(o_flags[4:2]), "compare flags not one-hot")
  `CAU_ASSERT(a_dz_only_div, clk, rst_n, (en && i_valid && i_flags.dz) |-> i_flags.is_div, "zero divisor flag outside divide")

endmodule

/* rtl/complex_arith_unit.sv */
// Top level of the complex arithmetic unit: front stages, divider cell chain, output.
// Throughput: one item per cycle; the front stages, a chain of DATA_WIDTH + 1
// quotient-bit cells and the output register all advance together.
// A result waiting in the output register stalls the whole pipeline.
// Reset (rst_n low, synchronous) empties every stage; no other state.
`include "complex_arith_unit_defines.svh"
module complex_arith_unit #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // a_re, a_im, b_re, b_im
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]    in_tdata,
  // mode
  input  logic [cau_pkg::MODE_W-1:0]           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // res_re, res_im
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]    out_tdata,
  // saturated, div_zero, is_equal, is_less, is_greater
  output logic [cau_pkg::FLAGS_W-1:0]          out_tuser
);
  import cau_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int MW  = 2 * W;
  localparam int RW  = 2 * W + 1;
  localparam int QB  = W + 1;
  localparam int OTW = ((2 * W + 7) / 8) * 8;

  logic en;

  logic              c_valid [QB+1];
  cau_flags_t        c_flags [QB+1];
  logic [MW-1:0]     c_num_re [QB+1];
  logic [MW-1:0]     c_num_im [QB+1];
  logic [MW-1:0]     c_den [QB+1];
  logic [RW-1:0]     c_rem_re [QB+1];
  logic [RW-1:0]     c_rem_im [QB+1];
  logic [QB-1:0]     c_q_re [QB+1];
  logic [QB-1:0]     c_q_im [QB+1];

  logic [W-1:0]      res_re, res_im;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  cau_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_mode  (in_tuser),
    .in_a_re  (in_tdata[W-1:0]),
    .in_a_im  (in_tdata[2*W-1:W]),
    .in_b_re  (in_tdata[3*W-1:2*W]),
    .in_b_im  (in_tdata[4*W-1:3*W]),
    .o_valid  (c_valid[0]),
    .o_flags  (c_flags[0]),
    .o_num_re (c_num_re[0]),
    .o_num_im (c_num_im[0]),
    .o_den    (c_den[0]),
    .o_rem_re (c_rem_re[0]),
    .o_rem_im (c_rem_im[0])
  );

  assign c_q_re[0] = '0;
  assign c_q_im[0] = '0;

  generate
    for (genvar i = 0; i < QB; i++) begin : g_cell
      cau_div_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .BIT_POS    (QB - 1 - i)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .i_valid  (c_valid[i]),
        .i_flags  (c_flags[i]),
        .i_num_re (c_num_re[i]),
        .i_num_im (c_num_im[i]),
        .i_den    (c_den[i]),
        .i_rem_re (c_rem_re[i]),
        .i_rem_im (c_rem_im[i]),
        .i_q_re   (c_q_re[i]),
        .i_q_im   (c_q_im[i]),
        .o_valid  (c_valid[i+1]),
        .o_flags  (c_flags[i+1]),
        .o_num_re (c_num_re[i+1]),
        .o_num_im (c_num_im[i+1]),
        .o_den    (c_den[i+1]),
        .o_rem_re (c_rem_re[i+1]),
        .o_rem_im (c_rem_im[i+1]),
        .o_q_re   (c_q_re[i+1]),
        .o_q_im   (c_q_im[i+1])
      );
    end
  endgenerate

  cau_out #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .i_valid  (c_valid[QB]),
    .i_flags  (c_flags[QB]),
    .i_num_re (c_num_re[QB]),
    .i_num_im (c_num_im[QB]),
    .i_q_re   (c_q_re[QB]),
    .i_q_im   (c_q_im[QB]),
    .o_valid  (out_tvalid),
    .o_res_re (res_re),
    .o_res_im (res_im),
    .o_flags  (out_tuser)
  );

  assign out_tdata = OTW'({res_im, res_re});

  `CAU_ASSERT(a_stall_blocks_input, clk, rst_n, (out_tvalid && !out_tready) |-> !in_tready, "input taken while output stalled")
  `CAU_ASSERT(a_result_kept, clk, rst_n, (out_tvalid && !out_tready) |=> out_tvalid, "stalled result dropped")

endmodule

/* tb/cau_checker.sv */
// Checker for the complex arithmetic unit: predicts each result and compares it.
module cau_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [4:0]  out_tuser,
  output int          fail_count,
  output int          pending,
  output int          result_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  typedef struct packed {
    logic [15:0] re;
    logic [15:0] im;
    logic        sat;
    logic        dz;
    logic        eq;
    logic        lt;
    logic        gt;
  } cplx_result_t;

  cplx_result_t expected_q[$];

  function automatic logic [15:0] clip16(longint v, ref logic sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 16'h7fff;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function automatic longint trunc_div(longint num, longint den);
    longint q;
    longint mag;
    mag = num < 0 ? -num : num;
    q = (mag * 256) / den;
    if (q > 65536) q = 65536;
    return num < 0 ? -q : q;
  endfunction

  function automatic cplx_result_t predict_cplx(logic [1:0] mode, logic [63:0] d);
    cplx_result_t r;
    longint ar, ai, br, bi, x, y, den;
    logic sat;
    ar = longint'($signed(d[15:0]));
    ai = longint'($signed(d[31:16]));
    br = longint'($signed(d[47:32]));
    bi = longint'($signed(d[63:48]));
    sat = 1'b0;
    r = '0;
    case (mode)
      MODE_ADD: begin
        x = ar + br;
        y = ai + bi;
      end
      MODE_SUB: begin
        x = ar - br;
        y = ai - bi;
      end
      MODE_MUL: begin
        x = ar * br - ai * bi;
        y = ar * bi + ai * br;
        x = x < 0 ? -((-x) >>> 8) : x >>> 8;
        y = y < 0 ? -((-y) >>> 8) : y >>> 8;
      end
      default: begin
        den = br * br + bi * bi;
        x = 0;
        y = 0;
        if (den == 0) r.dz = 1'b1;
        else begin
          x = trunc_div(ar * br + ai * bi, den);
          y = trunc_div(ai * br - ar * bi, den);
        end
      end
    endcase
    r.re = clip16(x, sat);
    r.im = clip16(y, sat);
    r.sat = sat;
    r.eq = (ar == br) && (ai == bi);
    r.lt = (ar < br) || (ar == br && ai < bi);
    r.gt = (ar > br) || (ar == br && ai > bi);
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    cplx_result_t exp_r;
    cplx_result_t got;
    if (!rst_n) begin
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_q.push_back(predict_cplx(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        result_count <= result_count + 1;
        got = {out_tdata[15:0], out_tdata[31:16], out_tuser[0], out_tuser[1],
               out_tuser[2], out_tuser[3], out_tuser[4]};
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            if (fail_count < 10)
              $display("mismatch: exp re=%h im=%h flags=%b got re=%h im=%h flags=%b",
                       exp_r.re, exp_r.im, {exp_r.sat, exp_r.dz, exp_r.eq, exp_r.lt, exp_r.gt},
                       got.re, got.im, {got.sat, got.dz, got.eq, got.lt, got.gt});
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* tb/testbench.sv */
// Stimulus and verdict for the complex arithmetic unit testbench.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [4:0]  out_tuser;
  int          fail_count;
  int          pending;
  int          result_count;
  bit          hold_out;

  complex_arith_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  cau_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [15:0] pick_part();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 16)) - 8);
      4: return 16'($urandom_range(0, 1023));
      5: return 16'(-int'($urandom_range(0, 1023)));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_item(logic [1:0] mode, logic [63:0] d);
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random(int n, bit gaps);
    logic [63:0] d;
    int g;
    for (int i = 0; i < n; i++) begin
      d = {pick_part(), pick_part(), pick_part(), pick_part()};
      if ($urandom_range(0, 7) == 0) d[63:32] = d[31:0];
      if ($urandom_range(0, 7) == 0) d[47:32] = d[15:0];
      send_item(2'($urandom_range(0, 3)), d);
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
        in_tvalid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
  endtask

  // receiver: random stalls, or a long hold while requested
  initial begin
    int g;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_out) begin
        out_tready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_out = 1'b0;
      end
      out_tready <= 1'b1;
      @(posedge clk);
      g = gap_len();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  initial begin
    logic [63:0] dir [16];
    hold_out = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = MODE_ADD;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    dir[0] = {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
    dir[1] = {16'h8000, 16'h8000, 16'h8000, 16'h8000};
    dir[2] = {16'h8000, 16'h7fff, 16'h7fff, 16'h8000};
    dir[3] = {16'h0000, 16'h0000, 16'h1234, 16'h0100};
    dir[4] = {16'h0000, 16'h0100, 16'h0100, 16'h0000};
    dir[5] = {16'h0001, 16'h0000, 16'h8000, 16'h7fff};
    dir[6] = {16'h0200, 16'hff00, 16'h0200, 16'hfe00};
    dir[7] = {16'hffff, 16'h0100, 16'h0100, 16'hff00};
    for (int k = 0; k < 8; k++)
      for (int m = 0; m < 4; m++) if ((k + m) % 2 == 0 || k < 4) send_item(2'(m), dir[k]);
    in_tvalid <= 1'b0;
    // pause until the pipeline drains
    while (pending != 0) @(posedge clk);
    hold_out = 1'b1;
    send_random(200, 1'b0);
    send_random(1420, 1'b1);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Ran %0d results over all four operations with saturation,", result_count);
    $display("zero divisors, operand compares and random stalls on both sides.");
    if (fail_count == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
